// ===== design/lsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared types and constants for the LSB stego stream decoder.
// ----------------------------------------------------------------------------
package lsd_pkg;

  localparam int unsigned SkipW  = 10;
  localparam int unsigned MagLenW = 4;
  localparam int unsigned MagW   = 64;
  localparam int unsigned AccW   = 32;
  localparam int unsigned RemW   = 31;
  localparam int unsigned BitCntW = 5;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 64;

  localparam logic [SkipW-1:0]   HeaderSkipRst  = SkipW'(54);
  localparam logic [MagLenW-1:0] MagicLenRst    = MagLenW'(2);
  localparam logic [MagLenW-1:0] MagicLenMax    = MagLenW'(8);

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_HEADER_SKIP  = 2'd0;
  localparam logic [1:0] REG_MAGIC_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAGIC_CHARS  = 2'd2;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'd0,
    PH_MAGIC  = 3'd1,
    PH_EXTLEN = 3'd2,
    PH_EXT    = 3'd3,
    PH_FLEN   = 3'd4,
    PH_DATA   = 3'd5,
    PH_IDLE   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    KIND_EXT_CHAR = 3'd0,
    KIND_DATA     = 3'd1,
    KIND_MISMATCH = 3'd2,
    KIND_EXT_LONG = 3'd3,
    KIND_EMPTY    = 3'd4
  } kind_t;

  typedef struct packed {
    logic [SkipW-1:0]   header_skip;
    logic [MagLenW-1:0] magic_length;
    logic [MagW-1:0]    magic_chars;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] decoded_byte;
    kind_t      kind;
    logic       last;
  } result_t;

endpackage

// ===== design/lsb_stego_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// lsb_stego_stream_decoder_core
// LSB steganography stream decoder: input register, decode engine, result reg.
// ----------------------------------------------------------------------------
// A byte goes from the input register through the engine to the result reg.
// Throughput: one image byte per cycle; the input register drains into the
//   decode engine whenever the result register is empty or being taken.
// Reset: rst (synchronous) empties both registers, returns the decoder to
//   header skip and loads register defaults (skip 54, magic length 2).
module lsb_stego_stream_decoder_core #(
  parameter int unsigned MAX_EXT_LEN = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                image_byte,
  input  logic                      start_of_image,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                decoded_byte,
  output logic [2:0]                kind,
  output logic                      last,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lsd_pkg::AddrW-1:0] paddr,
  input  logic [lsd_pkg::DataW-1:0] pwdata,
  output logic [lsd_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  lsd_pkg::cfg_t    cfg;
  lsd_pkg::result_t res;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_sof;
  logic       advance, fire, in_accept;

  lsd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance   = !out_valid || out_ready;
  assign fire      = s1_valid && advance;
  assign in_ready  = !s1_valid || advance;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte <= image_byte;
      s1_sof  <= start_of_image;
    end
  end

  lsd_engine #(
    .MAX_EXT_LEN (MAX_EXT_LEN)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .image_byte     (s1_byte),
    .start_of_image (s1_sof),
    .cfg            (cfg),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      decoded_byte <= res.decoded_byte;
      kind         <= res.kind;
      last         <= res.last;
    end
  end

endmodule

// ===== design/lsd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lsd_cfg_regs
// APB-style configuration registers: header skip, magic length, magic chars.
// ----------------------------------------------------------------------------
module lsd_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsd_pkg::AddrW-1:0]    paddr,
  input  logic [lsd_pkg::DataW-1:0]    pwdata,
  output logic [lsd_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  output lsd_pkg::cfg_t                cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[4:3];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_skip  <= lsd_pkg::HeaderSkipRst;
      cfg.magic_length <= lsd_pkg::MagicLenRst;
      cfg.magic_chars  <= '0;
    end else if (wr_en) begin
      if (reg_index == lsd_pkg::REG_HEADER_SKIP) begin
        cfg.header_skip <= pwdata[lsd_pkg::SkipW-1:0];
      end
      if (reg_index == lsd_pkg::REG_MAGIC_LENGTH) begin
        cfg.magic_length <= pwdata[lsd_pkg::MagLenW-1:0];
      end
      if (reg_index == lsd_pkg::REG_MAGIC_CHARS) begin
        cfg.magic_chars <= pwdata;
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_index)
      lsd_pkg::REG_HEADER_SKIP:  prdata = lsd_pkg::DataW'(cfg.header_skip);
      lsd_pkg::REG_MAGIC_LENGTH: prdata = lsd_pkg::DataW'(cfg.magic_length);
      lsd_pkg::REG_MAGIC_CHARS:  prdata = cfg.magic_chars;
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== design/lsd_engine.sv =====
// ----------------------------------------------------------------------------
// lsd_engine
// Decode state machine: one registered image byte in, at most one result out.
// ----------------------------------------------------------------------------
module lsd_engine #(
  parameter int unsigned MAX_EXT_LEN = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        image_byte,
  input  logic              start_of_image,
  input  lsd_pkg::cfg_t     cfg,
  output lsd_pkg::result_t  res
);

  localparam logic [lsd_pkg::AccW-1:0] ExtMax = lsd_pkg::AccW'(MAX_EXT_LEN);

  lsd_pkg::phase_t                  phase, phase_next;
  logic [lsd_pkg::SkipW-1:0]        skip_count, skip_count_next;
  logic [lsd_pkg::BitCntW-1:0]      bit_count, bit_count_next;
  logic [lsd_pkg::AccW-1:0]         shift_acc, shift_acc_next;
  logic [lsd_pkg::RemW-1:0]         remaining, remaining_next;
  logic [3:0]                       char_index, char_index_next;
  logic                             mismatch, mismatch_next;

  // state as seen after an optional restart
  lsd_pkg::phase_t                  cur_phase, eff_phase;
  logic [lsd_pkg::SkipW-1:0]        cur_skip;
  logic [lsd_pkg::BitCntW-1:0]      cur_bc, eff_bc, bc_new;
  logic [lsd_pkg::AccW-1:0]         cur_acc, eff_acc, acc_new;
  logic [lsd_pkg::RemW-1:0]         cur_rem, rem_dec;
  logic [3:0]                       cur_ci, ci_new;
  logic                             cur_mm, mm_new;
  logic [lsd_pkg::MagLenW-1:0]      eff_len;
  logic                             skipping, active, done8, done32, size_nonpos;
  logic [7:0]                       ch, magic_exp;

  assign eff_len   = (cfg.magic_length > lsd_pkg::MagicLenMax) ? lsd_pkg::MagicLenMax
                                                              : cfg.magic_length;
  assign cur_phase = start_of_image ? lsd_pkg::PH_SKIP : phase;
  assign cur_skip  = start_of_image ? '0 : skip_count;
  assign cur_bc    = start_of_image ? '0 : bit_count;
  assign cur_acc   = start_of_image ? '0 : shift_acc;
  assign cur_rem   = start_of_image ? '0 : remaining;
  assign cur_ci    = start_of_image ? '0 : char_index;
  assign cur_mm    = start_of_image ? 1'b0 : mismatch;

  assign skipping  = (cur_phase == lsd_pkg::PH_SKIP) && (cur_skip < cfg.header_skip);

  // leaving the header: payload starts with this very byte
  always_comb begin
    eff_phase = cur_phase;
    eff_bc    = cur_bc;
    eff_acc   = cur_acc;
    if (cur_phase == lsd_pkg::PH_SKIP) begin
      eff_phase = (eff_len != '0) ? lsd_pkg::PH_MAGIC : lsd_pkg::PH_EXTLEN;
      eff_bc    = '0;
      eff_acc   = '0;
    end
  end

  assign active = !skipping && (eff_phase != lsd_pkg::PH_IDLE)
                  && (eff_phase != lsd_pkg::PH_SKIP);

  assign acc_new     = {eff_acc[lsd_pkg::AccW-2:0], image_byte[0]};
  assign bc_new      = eff_bc + lsd_pkg::BitCntW'(1);
  assign done8       = (bc_new[2:0] == 3'd0);
  assign done32      = (bc_new == '0);
  assign ch          = acc_new[7:0];
  assign magic_exp   = cfg.magic_chars[{cur_ci[2:0], 3'b000} +: 8];
  assign ci_new      = cur_ci + 4'd1;
  assign mm_new      = cur_mm || (ch != magic_exp);
  assign size_nonpos = acc_new[lsd_pkg::AccW-1] || (acc_new == '0);
  assign rem_dec     = cur_rem - lsd_pkg::RemW'(1);

  // next state
  always_comb begin
    phase_next      = eff_phase;
    skip_count_next = cur_skip;
    bit_count_next  = eff_bc;
    shift_acc_next  = eff_acc;
    remaining_next  = cur_rem;
    char_index_next = cur_ci;
    mismatch_next   = cur_mm;
    if (skipping) begin
      phase_next      = cur_phase;
      bit_count_next  = cur_bc;
      shift_acc_next  = cur_acc;
      skip_count_next = cur_skip + lsd_pkg::SkipW'(1);
    end else if (active) begin
      shift_acc_next = acc_new;
      bit_count_next = bc_new;
      unique case (eff_phase)
        lsd_pkg::PH_MAGIC: begin
          if (done8) begin
            bit_count_next  = '0;
            mismatch_next   = mm_new;
            char_index_next = ci_new;
            if (ci_new >= eff_len) begin
              phase_next = mm_new ? lsd_pkg::PH_IDLE : lsd_pkg::PH_EXTLEN;
            end
          end
        end
        lsd_pkg::PH_EXTLEN: begin
          if (done32) begin
            if (size_nonpos) begin
              phase_next = lsd_pkg::PH_FLEN;
            end else if (acc_new > ExtMax) begin
              phase_next = lsd_pkg::PH_IDLE;
            end else begin
              remaining_next = acc_new[lsd_pkg::RemW-1:0];
              phase_next     = lsd_pkg::PH_EXT;
            end
          end
        end
        lsd_pkg::PH_EXT: begin
          if (done8) begin
            bit_count_next = '0;
            remaining_next = rem_dec;
            if (rem_dec == '0) begin
              phase_next = lsd_pkg::PH_FLEN;
            end
          end
        end
        lsd_pkg::PH_FLEN: begin
          if (done32) begin
            if (size_nonpos) begin
              phase_next = lsd_pkg::PH_IDLE;
            end else begin
              remaining_next = acc_new[lsd_pkg::RemW-1:0];
              phase_next     = lsd_pkg::PH_DATA;
            end
          end
        end
        lsd_pkg::PH_DATA: begin
          if (done8) begin
            bit_count_next = '0;
            remaining_next = rem_dec;
            if (rem_dec == '0) begin
              phase_next = lsd_pkg::PH_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result
  always_comb begin
    res.valid        = 1'b0;
    res.decoded_byte = '0;
    res.kind         = lsd_pkg::KIND_EXT_CHAR;
    res.last         = 1'b0;
    if (active) begin
      unique case (eff_phase)
        lsd_pkg::PH_MAGIC: begin
          if (done8 && (ci_new >= eff_len) && mm_new) begin
            res.valid = 1'b1;
            res.kind  = lsd_pkg::KIND_MISMATCH;
            res.last  = 1'b1;
          end
        end
        lsd_pkg::PH_EXTLEN: begin
          if (done32 && !size_nonpos && (acc_new > ExtMax)) begin
            res.valid = 1'b1;
            res.kind  = lsd_pkg::KIND_EXT_LONG;
            res.last  = 1'b1;
          end
        end
        lsd_pkg::PH_EXT: begin
          if (done8) begin
            res.valid        = 1'b1;
            res.decoded_byte = ch;
            res.kind         = lsd_pkg::KIND_EXT_CHAR;
          end
        end
        lsd_pkg::PH_FLEN: begin
          if (done32 && size_nonpos) begin
            res.valid = 1'b1;
            res.kind  = lsd_pkg::KIND_EMPTY;
            res.last  = 1'b1;
          end
        end
        lsd_pkg::PH_DATA: begin
          if (done8) begin
            res.valid        = 1'b1;
            res.decoded_byte = ch;
            res.kind         = lsd_pkg::KIND_DATA;
            res.last         = (rem_dec == '0);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= lsd_pkg::PH_SKIP;
      skip_count <= '0;
      bit_count  <= '0;
      shift_acc  <= '0;
      remaining  <= '0;
      char_index <= '0;
      mismatch   <= 1'b0;
    end else if (fire) begin
      phase      <= phase_next;
      skip_count <= skip_count_next;
      bit_count  <= bit_count_next;
      shift_acc  <= shift_acc_next;
      remaining  <= remaining_next;
      char_index <= char_index_next;
      mismatch   <= mismatch_next;
    end
  end

endmodule

// ===== design/lsd_checker.sv =====
// ----------------------------------------------------------------------------
// lsd_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module lsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] decoded_byte,
  input logic [2:0] kind,
  input logic       last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(decoded_byte)
                                && $stable(kind) && $stable(last))
    else $error("result changed while stalled");

  // error and done results end the stream and carry no character
  a_term_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == lsd_pkg::KIND_MISMATCH || kind == lsd_pkg::KIND_EXT_LONG
                  || kind == lsd_pkg::KIND_EMPTY) |-> last && decoded_byte == 8'd0)
    else $error("terminal result with bad last or byte");

  // extension characters never close the stream
  a_ext_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == lsd_pkg::KIND_EXT_CHAR |-> !last)
    else $error("extension char flagged last");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lsb_stego_stream_decoder_core lsd_checker u_lsd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .decoded_byte (decoded_byte),
  .kind         (kind),
  .last         (last)
);
